// ===== hdl/lr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

	// Command code carried by every request.
	typedef enum logic {
		OP_START = 1'b0,
		OP_NEXT  = 1'b1
	} op_t;

	// Depth of the command queue and of the result queue.
	localparam int QUEUE_DEPTH = 2;

	// Flags that the front end attaches to a decoded request.
	typedef struct packed {
		op_t  op;
		logic x_neg;
		logic y_neg;
		logic single;
	} dec_ctl_t;

	// Flags of one result.
	typedef struct packed {
		logic valid;
		logic last;
	} pix_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTR_BITS'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_BITS'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == CNT_BITS'($past(count_q) + 1'b1))
		else $error("queue fill count did not follow a lone write");

endmodule

`default_nettype wire

// ===== hdl/lr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         command,
	input  wire logic signed [COORD_BITS-1:0] from_x,
	input  wire logic signed [COORD_BITS-1:0] from_y,
	input  wire logic signed [COORD_BITS-1:0] to_x,
	input  wire logic signed [COORD_BITS-1:0] to_y,
	output lr_pkg::dec_ctl_t                  dec_ctl,
	output logic [COORD_BITS-1:0]             span_x,
	output logic [COORD_BITS-1:0]             span_y
);

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] ndx;
	logic signed [COORD_BITS:0] ndy;

	// Signed differences, one bit wider so they never wrap.
	assign dx  = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
	assign dy  = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
	assign ndx = -dx;
	assign ndy = -dy;

	// Absolute spans, step directions and the single-pixel case.
	always_comb begin
		span_x         = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		span_y         = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		dec_ctl.op     = lr_pkg::op_t'(command);
		dec_ctl.x_neg  = dx[COORD_BITS] || (dx == '0);
		dec_ctl.y_neg  = dy[COORD_BITS] || (dy == '0);
		dec_ctl.single = (dx == '0) && (dy == '0);
	end

endmodule

`default_nettype wire

// ===== hdl/lr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr_back #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_empty,
	output logic                              in_pop,
	input  wire lr_pkg::dec_ctl_t             dec_ctl,
	input  wire logic signed [COORD_BITS-1:0] from_x,
	input  wire logic signed [COORD_BITS-1:0] from_y,
	input  wire logic signed [COORD_BITS-1:0] to_x,
	input  wire logic signed [COORD_BITS-1:0] to_y,
	input  wire logic [COORD_BITS-1:0]        span_x,
	input  wire logic [COORD_BITS-1:0]        span_y,
	input  wire logic                         out_full,
	output logic                              out_push,
	output lr_pkg::pix_ctl_t                  pix_ctl,
	output logic signed [COORD_BITS-1:0]      pix_x,
	output logic signed [COORD_BITS-1:0]      pix_y
);

	localparam int ERR_BITS = COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
	logic [COORD_BITS-1:0]        span_x_q, span_y_q;
	logic                         x_neg_q, y_neg_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic                         busy_q;

	logic                         go;
	logic signed [ERR_BITS:0]     e2;
	logic signed [ERR_BITS:0]     sx_ext;
	logic signed [ERR_BITS:0]     neg_sy;
	logic                         step_x;
	logic                         step_y;
	logic signed [COORD_BITS-1:0] nxt_x, nxt_y;
	logic signed [ERR_BITS-1:0]   nxt_err;
	logic                         nxt_last;
	logic signed [ERR_BITS-1:0]   start_err;

	assign go       = !in_empty && !out_full;
	assign in_pop   = go;
	assign out_push = go;

	// One Bresenham step from the stored state.
	always_comb begin
		e2        = {err_q, 1'b0};
		sx_ext    = $signed({3'b000, span_x_q});
		neg_sy    = -$signed({3'b000, span_y_q});
		step_x    = e2 > neg_sy;
		step_y    = e2 < sx_ext;
		nxt_x     = pos_x_q;
		nxt_y     = pos_y_q;
		nxt_err   = err_q;
		if (step_x) begin
			nxt_x   = x_neg_q ? pos_x_q - 1'b1 : pos_x_q + 1'b1;
			nxt_err = nxt_err - $signed({2'b00, span_y_q});
		end
		if (step_y) begin
			nxt_y   = y_neg_q ? pos_y_q - 1'b1 : pos_y_q + 1'b1;
			nxt_err = nxt_err + $signed({2'b00, span_x_q});
		end
		nxt_last  = (nxt_x == goal_x_q) && (nxt_y == goal_y_q);
		start_err = $signed({2'b00, span_x}) - $signed({2'b00, span_y});
	end

	// Result of the request at the head of the command queue.
	always_comb begin
		pix_ctl = '0;
		pix_x   = '0;
		pix_y   = '0;
		case (dec_ctl.op)
			lr_pkg::OP_START: begin
				pix_ctl.valid = 1'b1;
				pix_ctl.last  = dec_ctl.single;
				pix_x         = from_x;
				pix_y         = from_y;
			end
			lr_pkg::OP_NEXT: begin
				if (busy_q) begin
					pix_ctl.valid = 1'b1;
					pix_ctl.last  = nxt_last;
					pix_x         = nxt_x;
					pix_y         = nxt_y;
				end
			end
			default: begin
				pix_ctl = '0;
			end
		endcase
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			span_x_q <= '0;
			span_y_q <= '0;
			x_neg_q  <= 1'b0;
			y_neg_q  <= 1'b0;
			err_q    <= '0;
			busy_q   <= 1'b0;
		end else if (go) begin
			if (dec_ctl.op == lr_pkg::OP_START) begin
				pos_x_q  <= from_x;
				pos_y_q  <= from_y;
				goal_x_q <= to_x;
				goal_y_q <= to_y;
				span_x_q <= span_x;
				span_y_q <= span_y;
				x_neg_q  <= dec_ctl.x_neg;
				y_neg_q  <= dec_ctl.y_neg;
				err_q    <= start_err;
				busy_q   <= !dec_ctl.single;
			end else if (busy_q) begin
				pos_x_q <= nxt_x;
				pos_y_q <= nxt_y;
				err_q   <= nxt_err;
				busy_q  <= !nxt_last;
			end
		end
	end

	a_never_parked_at_goal: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && (pos_x_q == goal_x_q) && (pos_y_q == goal_y_q)))
		else $error("line still active at its endpoint");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(go) && ($past(dec_ctl.op) == lr_pkg::OP_START))
		else $error("line became active without a start request");

	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (x_neg_q || (pos_x_q <= goal_x_q)) && (y_neg_q || (pos_y_q <= goal_y_q)))
		else $error("position stepped past the endpoint");

endmodule

`default_nettype wire

// ===== hdl/line_rasterizer.sv =====
// Bresenham line rasterizer, all octants.
// Requests enter through a queue-style port: a request is taken at a rising
// edge with push high and full low. A start request (command 0) loads both
// endpoints and returns the first pixel; a next request (command 1) advances
// one step along the active line and returns the new pixel. A next request
// with no active line returns a result with pixel_valid low and zero fields.
// Results leave through a second queue-style port: the oldest result is on
// the output ports while empty is low and is taken at an edge with pop high.
// Every request gives exactly one result. A request is held in the command
// queue and its result in the result queue before the result can be popped:
// the front end decodes spans and directions on the way into a two-entry
// command queue, and while the result queue has room the back end performs
// one step per cycle into a two-entry result queue, which sustains one
// request per cycle. When the receiver stalls, the result queue fills, the
// back end stops, then the command queue fills and full rises; nothing is lost.
// Reset clears both queues and leaves no line active.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         command,
	input  wire logic signed [COORD_BITS-1:0] from_x,
	input  wire logic signed [COORD_BITS-1:0] from_y,
	input  wire logic signed [COORD_BITS-1:0] to_x,
	input  wire logic signed [COORD_BITS-1:0] to_y,
	output logic                              empty,
	input  wire logic                         pop,
	output logic                              pixel_valid,
	output logic signed [COORD_BITS-1:0]      pixel_x,
	output logic signed [COORD_BITS-1:0]      pixel_y,
	output logic                              last_pixel
);

	localparam int CTL_BITS = $bits(lr_pkg::dec_ctl_t);
	localparam int CMD_BITS = CTL_BITS + 6 * COORD_BITS;
	localparam int PIX_BITS = $bits(lr_pkg::pix_ctl_t) + 2 * COORD_BITS;

	lr_pkg::dec_ctl_t             fe_ctl, q_ctl;
	logic [COORD_BITS-1:0]        fe_span_x, fe_span_y, q_span_x, q_span_y;
	logic signed [COORD_BITS-1:0] q_from_x, q_from_y, q_to_x, q_to_y;
	logic [CMD_BITS-1:0]          cmd_wdata, cmd_rdata;
	logic                         cmd_empty, cmd_pop;
	lr_pkg::pix_ctl_t             be_ctl, res_ctl;
	logic signed [COORD_BITS-1:0] be_x, be_y;
	logic [PIX_BITS-1:0]          res_wdata, res_rdata;
	logic                         res_full, res_push;

	// Front end: classify the request and form spans and directions.
	lr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.command (command),
		.from_x  (from_x),
		.from_y  (from_y),
		.to_x    (to_x),
		.to_y    (to_y),
		.dec_ctl (fe_ctl),
		.span_x  (fe_span_x),
		.span_y  (fe_span_y)
	);

	assign cmd_wdata = {fe_ctl, from_x, from_y, to_x, to_y, fe_span_x, fe_span_y};

	// Command queue between front and back end.
	lr_fifo #(.WIDTH(CMD_BITS), .DEPTH(lr_pkg::QUEUE_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_wdata),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign {q_ctl, q_from_x, q_from_y, q_to_x, q_to_y, q_span_x, q_span_y} = cmd_rdata;

	// Back end: line state and at most one step per request.
	lr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (cmd_empty),
		.in_pop   (cmd_pop),
		.dec_ctl  (q_ctl),
		.from_x   (q_from_x),
		.from_y   (q_from_y),
		.to_x     (q_to_x),
		.to_y     (q_to_y),
		.span_x   (q_span_x),
		.span_y   (q_span_y),
		.out_full (res_full),
		.out_push (res_push),
		.pix_ctl  (be_ctl),
		.pix_x    (be_x),
		.pix_y    (be_y)
	);

	assign res_wdata = {be_ctl, be_x, be_y};

	// Result queue toward the receiver.
	lr_fifo #(.WIDTH(PIX_BITS), .DEPTH(lr_pkg::QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {res_ctl, pixel_x, pixel_y} = res_rdata;
	assign pixel_valid = res_ctl.valid;
	assign last_pixel  = res_ctl.last;

endmodule

`default_nettype wire

// ===== tb/line_rasterizer_tb.sv =====
`timescale 1ns / 1ps

module line_rasterizer_tb;

	localparam int CB = 12;
	localparam int ITEM_COUNT = 1550;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic [CB-1:0] span_t;
	typedef logic signed [CB+1:0] err_t;

	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

	// Tracks the line being walked and holds the pixels still owed by the block.
	class pixel_scoreboard;
		coord_t cur_x, cur_y, end_x, end_y;
		span_t run_x, run_y;
		logic back_x, back_y;
		err_t err;
		logic active;
		pixel_t pending_q[$];
		int errors;

		function new();
			cur_x = '0;
			cur_y = '0;
			end_x = '0;
			end_y = '0;
			run_x = '0;
			run_y = '0;
			back_x = 1'b0;
			back_y = 1'b0;
			err = '0;
			active = 1'b0;
			errors = 0;
		endfunction

		// Advances the line walker by one accepted request and queues its pixel.
		function void note_request(lr_pkg::op_t op, coord_t fx, coord_t fy, coord_t tx,
			coord_t ty);
			logic signed [CB:0] dx, dy;
			logic signed [CB+2:0] twice, lim_x, lim_y;
			pixel_t px;
			px = '0;
			if (op == lr_pkg::OP_START) begin
				cur_x = fx;
				cur_y = fy;
				end_x = tx;
				end_y = ty;
				dx = {tx[CB-1], tx} - {fx[CB-1], fx};
				dy = {ty[CB-1], ty} - {fy[CB-1], fy};
				run_x = span_t'((dx < 0) ? -dx : dx);
				run_y = span_t'((dy < 0) ? -dy : dy);
				back_x = !(fx < tx);
				back_y = !(fy < ty);
				err = $signed({2'b00, run_x}) - $signed({2'b00, run_y});
				active = !((fx == tx) && (fy == ty));
				px = '{1'b1, fx, fy, !active};
			end else if (active) begin
				twice = {err, 1'b0};
				lim_x = $signed({3'b000, run_x});
				lim_y = $signed({3'b000, run_y});
				if (twice > -lim_y) begin
					err = err_t'(err - lim_y);
					cur_x = coord_t'(back_x ? cur_x - 1 : cur_x + 1);
				end
				if (twice < lim_x) begin
					err = err_t'(err + lim_x);
					cur_y = coord_t'(back_y ? cur_y - 1 : cur_y + 1);
				end
				active = !((cur_x == end_x) && (cur_y == end_y));
				px = '{1'b1, cur_x, cur_y, !active};
			end
			pending_q.push_back(px);
		endfunction

		// Compares one popped result against the oldest owed pixel.
		function void check_pixel(logic valid, coord_t x, coord_t y, logic last);
			pixel_t want;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("pixel error: unexpected result valid=%0b x=%0d y=%0d last=%0b",
						valid, x, y, last);
				return;
			end
			want = pending_q.pop_front();
			if (want.valid !== valid || want.x !== x || want.y !== y || want.last !== last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("pixel error: expected valid=%0b x=%0d y=%0d last=%0b, %s",
						want.valid, want.x, want.y, want.last,
						$sformatf("got valid=%0b x=%0d y=%0d last=%0b", valid, x, y, last));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic command = lr_pkg::OP_NEXT;
	coord_t from_x = '0;
	coord_t from_y = '0;
	coord_t to_x = '0;
	coord_t to_y = '0;
	logic full;
	logic empty;
	logic pixel_valid;
	coord_t pixel_x;
	coord_t pixel_y;
	logic last_pixel;

	pixel_scoreboard sb;
	int sent = 0;
	int idle_cycles = 0;
	bit send_quiet = 1'b0;
	bit take_quiet = 1'b0;

	line_rasterizer #(
		.COORD_BITS(CB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.from_x(from_x),
		.from_y(from_y),
		.to_x(to_x),
		.to_y(to_y),
		.empty(empty),
		.pop(pop),
		.pixel_valid(pixel_valid),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.last_pixel(last_pixel)
	);

	always #1 clk = ~clk;

	// Stops a hung run: counts cycles in which neither side moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("line_rasterizer: mismatch");
				$finish;
			end
		end
	end

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	// Picks a coordinate up to 9 steps away from base, kept inside the field range.
	function automatic coord_t near_coord(coord_t base);
		int v;
		v = int'(base) + int'($urandom_range(0, 18)) - 9;
		if (v < -(1 << (CB - 1)))
			v = -(1 << (CB - 1));
		if (v > (1 << (CB - 1)) - 1)
			v = (1 << (CB - 1)) - 1;
		return coord_t'(v);
	endfunction

	// Offers one request after a random gap and holds it until the block takes it.
	task automatic send_request(lr_pkg::op_t op, coord_t fx, coord_t fy, coord_t tx,
		coord_t ty);
		int gap;
		if ($urandom_range(0, 31) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= op;
		from_x <= fx;
		from_y <= fy;
		to_x <= tx;
		to_y <= ty;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_request(op, fx, fy, tx, ty);
		sent++;
	endtask

	task automatic send_next();
		send_request(lr_pkg::OP_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	// Pops one result after a random stall and checks it.
	task automatic take_result();
		int gap;
		if ($urandom_range(0, 31) == 0)
			take_quiet = !take_quiet;
		gap = take_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pop <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pop <= 1'b1;
		do @(posedge clk); while (empty !== 1'b0);
		sb.check_pixel(pixel_valid, pixel_x, pixel_y, last_pixel);
	endtask

	initial begin
		@(posedge arst_n);
		forever take_result();
	end

	initial begin
		int kind;
		int steps;
		coord_t fx, fy, tx, ty;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Pull with no line active, then a line of a single pixel.
		send_next();
		send_request(lr_pkg::OP_START, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
		send_next();

		// Shallow line to its end, then one pull past the end.
		send_request(lr_pkg::OP_START, 12'sd0, 12'sd0, 12'sd3, 12'sd1);
		repeat (4) send_next();

		// Line walking toward negative x and y.
		send_request(lr_pkg::OP_START, 12'sd2, -12'sd1, -12'sd1, -12'sd3);
		repeat (3) send_next();

		// Corner to corner lines; each start drops the line before it.
		send_request(lr_pkg::OP_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
		repeat (2) send_next();
		send_request(lr_pkg::OP_START, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048);
		send_next();
		send_request(lr_pkg::OP_START, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
		send_next();

		// Vertical line to its end and beyond.
		send_request(lr_pkg::OP_START, 12'sd0, 12'sd0, 12'sd0, -12'sd2);
		repeat (3) send_next();

		// Mostly short lines walked to the end, with some cut short or overrun,
		// some long lines pulled only briefly, and lone requests as noise.
		while (sent < ITEM_COUNT) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_request(lr_pkg::op_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
					rand_coord(), rand_coord());
			end else begin
				fx = rand_coord();
				fy = rand_coord();
				if (kind == 1) begin
					tx = rand_coord();
					ty = rand_coord();
					steps = $urandom_range(0, 16);
				end else begin
					tx = near_coord(fx);
					ty = near_coord(fy);
					steps = (int'(tx) > int'(fx)) ? int'(tx) - int'(fx) : int'(fx) - int'(tx);
					if ((int'(ty) - int'(fy)) > steps)
						steps = int'(ty) - int'(fy);
					if ((int'(fy) - int'(ty)) > steps)
						steps = int'(fy) - int'(ty);
					case ($urandom_range(0, 3))
						0: begin
							steps = $urandom_range(0, steps);
						end
						1: begin
							steps = steps + $urandom_range(1, 2);
						end
						default: begin
						end
					endcase
				end
				send_request(lr_pkg::OP_START, fx, fy, tx, ty);
				repeat (steps) send_next();
			end
		end
		push <= 1'b0;

		// Let every owed pixel come out, then allow for any stray result.
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("line_rasterizer: match");
		end else begin
			$display("line_rasterizer: mismatch");
		end
		$finish;
	end

endmodule
